FILE: rtl/core/paging_recommendation_ie_parser_macros.svh
// assertion helpers for the paging recommendation element parser
`ifndef PAGING_RECOMMENDATION_IE_PARSER_MACROS_SVH
`define PAGING_RECOMMENDATION_IE_PARSER_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define PRIE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prie assertion failed");

// antecedent implies consequent in the next cycle
`define PRIE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prie assertion failed");

`else

`define PRIE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PRIE_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/prie_pkg.sv
package prie_pkg;

    localparam int MAX_CELLS_DEF = 16;
    localparam int MAX_ENBS_DEF  = 16;
    localparam int CNT_W         = 5;

    localparam logic [15:0] TAG_CELL = 16'd214;
    localparam logic [15:0] TAG_ENB  = 16'd215;

    localparam logic [7:0] CRIT_MASK   = 8'hc0;
    localparam logic [7:0] CHOICE_MASK = 8'h10;
    localparam logic [7:0] MACRO_MASK  = 8'hc0;

    // byte positions inside an item
    localparam logic [3:0] POS_TAG_HI       = 4'd0;
    localparam logic [3:0] POS_TAG_LO       = 4'd1;
    localparam logic [3:0] POS_CRIT         = 4'd2;
    localparam logic [3:0] POS_CHOICE       = 4'd4;
    localparam logic [3:0] POS_PLMN_FIRST   = 4'd5;
    localparam logic [3:0] POS_PLMN_LAST    = 4'd7;
    localparam logic [3:0] POS_CELL_ID_LO   = 4'd8;
    localparam logic [3:0] POS_CELL_ID_HI   = 4'd11;
    localparam logic [3:0] POS_STAY_HI      = 4'd12;
    localparam logic [3:0] POS_CELL_LAST    = 4'd13;
    localparam logic [3:0] POS_MACRO        = 4'd8;
    localparam logic [3:0] POS_ENB_ID_FIRST = 4'd9;
    localparam logic [3:0] POS_ENB_ID_MID   = 4'd10;
    localparam logic [3:0] POS_ENB_LAST     = 4'd11;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CELLS,
        PH_ENB_HDR,
        PH_ENBS
    } phase_t;

    typedef enum logic {
        KIND_CELL,
        KIND_ENB
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_CELL_TAG,
        ERR_ENB_TAG,
        ERR_ENB_CHOICE
    } err_t;

    typedef struct packed {
        kind_t        item_kind;
        logic [1:0]   criticality;
        logic [23:0]  plmn_id;
        logic [31:0]  identity;
        logic [15:0]  stay_time;
        logic [3:0]   item_number;
        logic         last_item;
        err_t         error_code;
    } res_t;

endpackage

FILE: rtl/core/prie_parse.sv
module prie_parse
    import prie_pkg::*;
#(
    parameter int MAX_CELLS = MAX_CELLS_DEF,
    parameter int MAX_ENBS  = MAX_ENBS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       msg_start,
    output logic       res_valid,
    output res_t       res
);

    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_CELLS);
    localparam logic [CNT_W-1:0] MAX_E = CNT_W'(MAX_ENBS);

    phase_t           phase_reg, phase_next;
    logic [3:0]       pos_reg, pos_next;
    logic [CNT_W-1:0] items_reg, items_next;
    logic [3:0]       index_reg, index_next;
    logic [7:0]       tag_hi_reg, tag_hi_next;
    logic [1:0]       crit_reg, crit_next;
    logic [23:0]      plmn_reg, plmn_next;
    logic [31:0]      id_reg, id_next;
    logic [7:0]       stay_hi_reg, stay_hi_next;

    logic             fail;
    logic             done;
    logic             last_enb;
    err_t             err;
    logic [CNT_W-1:0] items_dec;
    logic [CNT_W-1:0] cell_cnt;
    logic [CNT_W-1:0] enb_cnt;

    assign items_dec = items_reg - CNT_W'(1);
    assign last_enb  = (items_reg <= CNT_W'(1));

    always_comb
    begin
        cell_cnt = {1'b0, data_byte[3:0]} + CNT_W'(1);
        if (cell_cnt > MAX_C)
        begin
            cell_cnt = MAX_C;
        end
        enb_cnt = {1'b0, data_byte[5:2]} + CNT_W'(1);
        if (enb_cnt > MAX_E)
        begin
            enb_cnt = MAX_E;
        end
    end

    // item checks and completion
    always_comb
    begin
        fail = 1'b0;
        done = 1'b0;
        err  = ERR_NONE;
        if (!msg_start)
        begin
            unique case (phase_reg)
                PH_CELLS:
                begin
                    if (pos_reg == POS_TAG_LO && {tag_hi_reg, data_byte} != TAG_CELL)
                    begin
                        fail = 1'b1;
                        err  = ERR_CELL_TAG;
                    end
                    else if (pos_reg >= POS_CELL_LAST)
                    begin
                        done = 1'b1;
                    end
                end
                PH_ENBS:
                begin
                    if (pos_reg == POS_TAG_LO && {tag_hi_reg, data_byte} != TAG_ENB)
                    begin
                        fail = 1'b1;
                        err  = ERR_ENB_TAG;
                    end
                    else if ((pos_reg == POS_CHOICE && (data_byte & CHOICE_MASK) != 8'd0)
                        || (pos_reg == POS_MACRO && (data_byte & MACRO_MASK) != 8'd0))
                    begin
                        fail = 1'b1;
                        err  = ERR_ENB_CHOICE;
                    end
                    else if (pos_reg >= POS_ENB_LAST)
                    begin
                        done = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        if (msg_start)
        begin
            phase_next = PH_CELLS;
        end
        else
        begin
            unique case (phase_reg)
                PH_ENB_HDR: phase_next = PH_ENBS;
                PH_CELLS:
                begin
                    if (fail)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (done && items_dec == '0)
                    begin
                        phase_next = PH_ENB_HDR;
                    end
                end
                PH_ENBS:
                begin
                    if (fail || (done && last_enb))
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    // field capture and counters
    always_comb
    begin
        pos_next     = pos_reg;
        items_next   = items_reg;
        index_next   = index_reg;
        tag_hi_next  = tag_hi_reg;
        crit_next    = crit_reg;
        plmn_next    = plmn_reg;
        id_next      = id_reg;
        stay_hi_next = stay_hi_reg;
        if (msg_start || phase_reg == PH_ENB_HDR)
        begin
            items_next   = msg_start ? cell_cnt : enb_cnt;
            index_next   = '0;
            pos_next     = '0;
            tag_hi_next  = '0;
            crit_next    = '0;
            plmn_next    = '0;
            id_next      = '0;
            stay_hi_next = '0;
        end
        else if (phase_reg == PH_CELLS || phase_reg == PH_ENBS)
        begin
            pos_next = pos_reg + 4'd1;
            if (pos_reg == POS_TAG_HI)
            begin
                tag_hi_next = data_byte;
            end
            if (pos_reg == POS_CRIT)
            begin
                crit_next = data_byte[7:6];
            end
            if (pos_reg >= POS_PLMN_FIRST && pos_reg <= POS_PLMN_LAST)
            begin
                plmn_next = {plmn_reg[15:0], data_byte};
            end
            if (phase_reg == PH_CELLS)
            begin
                if (pos_reg >= POS_CELL_ID_LO && pos_reg <= POS_CELL_ID_HI)
                begin
                    id_next = {id_reg[23:0], data_byte};
                end
                if (pos_reg == POS_STAY_HI)
                begin
                    stay_hi_next = data_byte;
                end
            end
            else if (pos_reg == POS_ENB_ID_FIRST || pos_reg == POS_ENB_ID_MID)
            begin
                id_next = {8'd0, id_reg[15:0], data_byte};
            end
            if (fail)
            begin
                pos_next   = '0;
                items_next = '0;
            end
            else if (done)
            begin
                items_next   = (phase_reg == PH_ENBS && last_enb) ? '0 : items_dec;
                index_next   = index_reg + 4'd1;
                pos_next     = '0;
                tag_hi_next  = '0;
                crit_next    = '0;
                plmn_next    = '0;
                id_next      = '0;
                stay_hi_next = '0;
            end
        end
    end

    always_comb
    begin
        res_valid       = step && (fail || done);
        res.item_kind   = (phase_reg == PH_ENBS) ? KIND_ENB : KIND_CELL;
        res.item_number = index_reg;
        res.error_code  = err;
        res.criticality = '0;
        res.plmn_id     = '0;
        res.identity    = '0;
        res.stay_time   = '0;
        res.last_item   = 1'b1;
        if (!fail)
        begin
            res.criticality = crit_reg;
            res.plmn_id     = plmn_reg;
            if (phase_reg == PH_ENBS)
            begin
                res.identity  = {8'd0, id_reg[15:0], data_byte};
                res.last_item = last_enb;
            end
            else
            begin
                res.identity  = id_reg;
                res.stay_time = {stay_hi_reg, data_byte};
                res.last_item = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            pos_reg     <= '0;
            items_reg   <= '0;
            index_reg   <= '0;
            tag_hi_reg  <= '0;
            crit_reg    <= '0;
            plmn_reg    <= '0;
            id_reg      <= '0;
            stay_hi_reg <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            items_reg   <= items_next;
            index_reg   <= index_next;
            tag_hi_reg  <= tag_hi_next;
            crit_reg    <= crit_next;
            plmn_reg    <= plmn_next;
            id_reg      <= id_next;
            stay_hi_reg <= stay_hi_next;
        end
    end

endmodule

FILE: rtl/core/paging_recommendation_ie_parser.sv
// an input beat is held in the input register, then its result in the result register
// throughput: one byte per cycle unless output stalls; one logic pass on the held byte
// a result waiting downstream stalls input only once the input register is also full
// reset clears the parser to idle, awaiting a byte flagged as message start
`include "paging_recommendation_ie_parser_macros.svh"

module paging_recommendation_ie_parser
    import prie_pkg::*;
#(
    parameter int MAX_CELLS = MAX_CELLS_DEF,
    parameter int MAX_ENBS  = MAX_ENBS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // msg_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // criticality, plmn_id, identity, stay_time, item_number, error_code
    output logic [79:0] m_axis_tdata,
    output logic        m_axis_tuser,   // item_kind
    output logic        m_axis_tlast    // last_item
);

    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       start_reg;
    logic       out_valid_reg;
    res_t       res_reg;
    logic       advance;
    logic       res_valid;
    res_t       res;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    prie_parse #(
        .MAX_CELLS (MAX_CELLS),
        .MAX_ENBS  (MAX_ENBS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (byte_reg),
        .msg_start (start_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= res_valid;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            byte_reg  <= s_axis_tdata;
            start_reg <= s_axis_tuser;
        end
        if (advance && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = res_reg.item_kind;
    assign m_axis_tlast  = res_reg.last_item;
    assign m_axis_tdata  = {res_reg.error_code, res_reg.item_number, res_reg.stay_time,
                            res_reg.identity, res_reg.plmn_id, res_reg.criticality};

    `PRIE_ASSERT_IMP(a_err_is_last, clk, rst_n, out_valid_reg && res_reg.error_code != ERR_NONE, res_reg.last_item)
    `PRIE_ASSERT_IMP(a_err_zero_payload, clk, rst_n, out_valid_reg && res_reg.error_code != ERR_NONE, res_reg.plmn_id == '0 && res_reg.identity == '0 && res_reg.stay_time == '0)
    `PRIE_ASSERT_IMP(a_cell_not_last, clk, rst_n, out_valid_reg && res_reg.item_kind == KIND_CELL && res_reg.error_code == ERR_NONE, !res_reg.last_item)
    `PRIE_ASSERT_NXT(a_byte_held, clk, rst_n, in_valid_reg && !advance, in_valid_reg && $stable(byte_reg))
    `PRIE_ASSERT_IMP(a_enb_no_stay, clk, rst_n, out_valid_reg && res_reg.item_kind == KIND_ENB, res_reg.stay_time == '0 && res_reg.identity[31:24] == '0)

endmodule

FILE: sim/tb_paging_recommendation_ie_parser.sv
`timescale 1ns / 1ps

module tb_paging_recommendation_ie_parser;
    import prie_pkg::*;

    typedef struct packed {
        logic       start;
        logic [7:0] data;
    } beat_t;

    typedef enum {
        FAULT_NONE,
        FAULT_CELL_TAG,
        FAULT_ENB_TAG,
        FAULT_CHOICE,
        FAULT_MACRO
    } fault_t;

    localparam int NO_CUT        = 1 << 30;
    localparam int RANDOM_BYTES  = 950;
    localparam int HOLDOFF_AT    = 1000;
    localparam int HOLDOFF_LEN   = 300;
    localparam int MAX_REPORTS   = 10;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    paging_recommendation_ie_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    beat_t pending_bytes[$];
    res_t  expected_items[$];
    int    cut_left = NO_CUT;

    // parser state as predicted
    phase_t      cur_phase;
    logic [3:0]  byte_pos;
    logic [4:0]  items_remaining;
    logic [3:0]  item_idx;
    logic [7:0]  tag_msb;
    logic [1:0]  held_crit;
    logic [23:0] plmn_shift;
    logic [31:0] id_shift;
    logic [7:0]  stay_msb;

    int mismatch_count;
    int results_seen;
    int error_results;
    int elements_sent;
    int bytes_accepted;

    int burst_left;
    int gap_left;
    int holdoff_left;
    bit holdoff_done;
    int cycle_count;
    int ready_mode;
    beat_t next_beat;
    res_t  got_item;
    res_t  want_item;

    task automatic clear_item();
        byte_pos   = '0;
        tag_msb    = '0;
        held_crit  = '0;
        plmn_shift = '0;
        id_shift   = '0;
        stay_msb   = '0;
    endtask

    task automatic parse_fault(input kind_t kind, input err_t code);
        res_t r;
        r             = '0;
        r.item_kind   = kind;
        r.item_number = item_idx;
        r.last_item   = 1'b1;
        r.error_code  = code;
        expected_items.push_back(r);
        cur_phase       = PH_IDLE;
        byte_pos        = '0;
        items_remaining = '0;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic start);
        res_t       r;
        logic [4:0] count;
        logic [3:0] pos;
        pos = byte_pos;
        r   = '0;
        if (start)
        begin
            count = {1'b0, b[3:0]} + 5'd1;
            if (count > MAX_CELLS_DEF)
                count = 5'(MAX_CELLS_DEF);
            items_remaining = count;
            item_idx        = '0;
            cur_phase       = PH_CELLS;
            clear_item();
            return;
        end
        case (cur_phase)
            PH_ENB_HDR:
            begin
                count = {1'b0, b[5:2]} + 5'd1;
                if (count > MAX_ENBS_DEF)
                    count = 5'(MAX_ENBS_DEF);
                items_remaining = count;
                item_idx        = '0;
                cur_phase       = PH_ENBS;
                clear_item();
            end
            PH_CELLS:
            begin
                byte_pos = pos + 4'd1;
                if (pos == POS_TAG_HI)
                    tag_msb = b;
                else if (pos == POS_TAG_LO)
                begin
                    if ({tag_msb, b} != TAG_CELL)
                        parse_fault(KIND_CELL, ERR_CELL_TAG);
                end
                else if (pos == POS_CRIT)
                    held_crit = 2'((b & CRIT_MASK) >> 6);
                else if (pos >= POS_PLMN_FIRST && pos <= POS_PLMN_LAST)
                    plmn_shift = {plmn_shift[15:0], b};
                else if (pos >= POS_CELL_ID_LO && pos <= POS_CELL_ID_HI)
                    id_shift = {id_shift[23:0], b};
                else if (pos == POS_STAY_HI)
                    stay_msb = b;
                else if (pos >= POS_CELL_LAST)
                begin
                    r.item_kind   = KIND_CELL;
                    r.criticality = held_crit;
                    r.plmn_id     = plmn_shift;
                    r.identity    = id_shift;
                    r.stay_time   = {stay_msb, b};
                    r.item_number = item_idx;
                    r.last_item   = 1'b0;
                    r.error_code  = ERR_NONE;
                    expected_items.push_back(r);
                    items_remaining = items_remaining - 5'd1;
                    item_idx        = item_idx + 4'd1;
                    clear_item();
                    if (items_remaining == 0)
                        cur_phase = PH_ENB_HDR;
                end
            end
            PH_ENBS:
            begin
                byte_pos = pos + 4'd1;
                if (pos == POS_TAG_HI)
                    tag_msb = b;
                else if (pos == POS_TAG_LO)
                begin
                    if ({tag_msb, b} != TAG_ENB)
                        parse_fault(KIND_ENB, ERR_ENB_TAG);
                end
                else if (pos == POS_CRIT)
                    held_crit = 2'((b & CRIT_MASK) >> 6);
                else if (pos == POS_CHOICE)
                begin
                    if ((b & CHOICE_MASK) != 0)
                        parse_fault(KIND_ENB, ERR_ENB_CHOICE);
                end
                else if (pos >= POS_PLMN_FIRST && pos <= POS_PLMN_LAST)
                    plmn_shift = {plmn_shift[15:0], b};
                else if (pos == POS_MACRO)
                begin
                    if ((b & MACRO_MASK) != 0)
                        parse_fault(KIND_ENB, ERR_ENB_CHOICE);
                end
                else if (pos >= POS_ENB_ID_FIRST && pos <= POS_ENB_ID_MID)
                    id_shift = {8'h00, id_shift[15:0], b};
                else if (pos >= POS_ENB_LAST)
                begin
                    r.item_kind   = KIND_ENB;
                    r.criticality = held_crit;
                    r.plmn_id     = plmn_shift;
                    r.identity    = {8'h00, id_shift[15:0], b};
                    r.stay_time   = '0;
                    r.item_number = item_idx;
                    r.last_item   = (items_remaining <= 5'd1);
                    r.error_code  = ERR_NONE;
                    expected_items.push_back(r);
                    items_remaining = items_remaining - 5'd1;
                    item_idx        = item_idx + 4'd1;
                    clear_item();
                    if (r.last_item)
                    begin
                        cur_phase       = PH_IDLE;
                        items_remaining = '0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // stimulus building
    task automatic emit(input logic [7:0] b, input logic start);
        if (cut_left > 0)
        begin
            pending_bytes.push_back('{start: start, data: b});
            cut_left--;
        end
    endtask

    task automatic push_cell(input logic [15:0] tag, input logic [7:0] crit_b,
                             input logic [23:0] plmn, input logic [31:0] id,
                             input logic [15:0] stay);
        emit(tag[15:8], 1'b0);
        emit(tag[7:0], 1'b0);
        emit(crit_b, 1'b0);
        emit(8'($urandom), 1'b0);
        emit(8'($urandom), 1'b0);
        for (int k = 2; k >= 0; k--)
            emit(plmn[8*k +: 8], 1'b0);
        for (int k = 3; k >= 0; k--)
            emit(id[8*k +: 8], 1'b0);
        emit(stay[15:8], 1'b0);
        emit(stay[7:0], 1'b0);
    endtask

    task automatic push_enb(input logic [15:0] tag, input logic [7:0] crit_b,
                            input logic [7:0] choice_b, input logic [23:0] plmn,
                            input logic [7:0] macro_b, input logic [23:0] id);
        emit(tag[15:8], 1'b0);
        emit(tag[7:0], 1'b0);
        emit(crit_b, 1'b0);
        emit(8'($urandom), 1'b0);
        emit(choice_b, 1'b0);
        for (int k = 2; k >= 0; k--)
            emit(plmn[8*k +: 8], 1'b0);
        emit(macro_b, 1'b0);
        for (int k = 2; k >= 0; k--)
            emit(id[8*k +: 8], 1'b0);
    endtask

    function automatic logic [15:0] corrupt_tag(input logic [15:0] good);
        logic [15:0] t;
        if ($urandom_range(0, 1) == 0)
            t = good ^ (16'd1 << $urandom_range(0, 15));
        else
            t = 16'($urandom);
        if (t == good)
            t = ~good;
        return t;
    endfunction

    task automatic queue_element(input int n_cells, input int n_enbs,
                                 input fault_t fault, input int fault_item);
        logic [15:0] tag;
        logic [7:0]  choice_b;
        logic [7:0]  macro_b;
        emit({4'($urandom), 4'(n_cells - 1)}, 1'b1);
        for (int i = 0; i < n_cells; i++)
        begin
            tag = (fault == FAULT_CELL_TAG && i == fault_item) ? corrupt_tag(TAG_CELL)
                                                               : TAG_CELL;
            push_cell(tag, 8'($urandom), 24'($urandom), $urandom, 16'($urandom));
        end
        emit({2'($urandom), 4'(n_enbs - 1), 2'($urandom)}, 1'b0);
        for (int j = 0; j < n_enbs; j++)
        begin
            tag      = (fault == FAULT_ENB_TAG && j == fault_item) ? corrupt_tag(TAG_ENB)
                                                                   : TAG_ENB;
            choice_b = 8'($urandom) & ~CHOICE_MASK;
            macro_b  = 8'($urandom) & ~MACRO_MASK;
            if (fault == FAULT_CHOICE && j == fault_item)
                choice_b = choice_b | CHOICE_MASK;
            if (fault == FAULT_MACRO && j == fault_item)
                macro_b = macro_b | (8'($urandom_range(1, 3)) << 6);
            push_enb(tag, 8'($urandom), choice_b, 24'($urandom), macro_b, 24'($urandom));
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("mismatch at result %0d: %s expected %0h got %0h",
                         results_seen, field, want, got);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // sender: bursts with gaps, no gaps while the receiver holds off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_byte(s_axis_tdata, s_axis_tuser);
                bytes_accepted++;
                if (s_axis_tuser)
                    elements_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0 && holdoff_left == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    gap_left--;
                end
                else if (pending_bytes.size() > 0)
                begin
                    next_beat = pending_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_beat.data;
                    s_axis_tuser  <= next_beat.start;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: changing stall pattern plus one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            cycle_count++;
            if (holdoff_left > 0)
            begin
                holdoff_left  <= holdoff_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!holdoff_done && cycle_count >= HOLDOFF_AT)
            begin
                holdoff_done = 1'b1;
                holdoff_left  <= HOLDOFF_LEN;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (cycle_count % 97 == 0)
                    ready_mode = $urandom_range(0, 3);
                case (ready_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 1) == 0);
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_item.item_kind   = kind_t'(m_axis_tuser);
            got_item.criticality = m_axis_tdata[1:0];
            got_item.plmn_id     = m_axis_tdata[25:2];
            got_item.identity    = m_axis_tdata[57:26];
            got_item.stay_time   = m_axis_tdata[73:58];
            got_item.item_number = m_axis_tdata[77:74];
            got_item.last_item   = m_axis_tlast;
            got_item.error_code  = err_t'(m_axis_tdata[79:78]);
            if (expected_items.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result %0d: %p", results_seen, got_item);
            end
            else
            begin
                want_item = expected_items.pop_front();
                check_field("item_kind", want_item.item_kind, got_item.item_kind);
                check_field("criticality", want_item.criticality, got_item.criticality);
                check_field("plmn_id", want_item.plmn_id, got_item.plmn_id);
                check_field("identity", want_item.identity, got_item.identity);
                check_field("stay_time", want_item.stay_time, got_item.stay_time);
                check_field("item_number", want_item.item_number, got_item.item_number);
                check_field("last_item", want_item.last_item, got_item.last_item);
                check_field("error_code", want_item.error_code, got_item.error_code);
            end
            results_seen++;
            if (got_item.error_code != ERR_NONE)
                error_results++;
        end
    end

    initial
    begin
        int     directed_len;
        int     sel;
        int     n_cells;
        int     n_enbs;
        fault_t fault;

        cur_phase       = PH_IDLE;
        items_remaining = '0;
        item_idx        = '0;
        clear_item();
        ready_mode = 0;

        // idle bytes are dropped
        emit(8'hff, 1'b0);
        emit(8'h00, 1'b0);
        // single cell and eNB, field extremes, ignored header bits set
        emit(8'hf0, 1'b1);
        push_cell(TAG_CELL, 8'hff, 24'hffffff, 32'hffffffff, 16'hffff);
        emit(8'hc3, 1'b0);
        push_enb(TAG_ENB, 8'h3f, 8'hef, 24'h000000, 8'h3f, 24'h000000);
        // two of each
        emit(8'h01, 1'b1);
        push_cell(TAG_CELL, 8'h40, 24'h000000, 32'h00000000, 16'h0000);
        push_cell(TAG_CELL, 8'h80, 24'h123456, 32'h89abcdef, 16'h0100);
        emit(8'h04, 1'b0);
        push_enb(TAG_ENB, 8'hc0, 8'h00, 24'hffffff, 8'h00, 24'hffffff);
        push_enb(TAG_ENB, 8'h80, 8'h00, 24'h5a5a5a, 8'h00, 24'ha5a5a5);
        // bad cell tag, then trailing bytes ignored
        emit(8'h00, 1'b1);
        push_cell(16'h00d7, 8'h00, 24'h1, 32'h1, 16'h1);
        emit(8'h55, 1'b0);
        // bad eNB tag
        emit(8'h00, 1'b1);
        push_cell(TAG_CELL, 8'h00, 24'h2, 32'h2, 16'h2);
        emit(8'h00, 1'b0);
        push_enb(16'h01d7, 8'h00, 8'h00, 24'h3, 8'h00, 24'h3);
        // choice bit set
        emit(8'h00, 1'b1);
        push_cell(TAG_CELL, 8'h00, 24'h4, 32'h4, 16'h4);
        emit(8'h00, 1'b0);
        push_enb(TAG_ENB, 8'h00, CHOICE_MASK, 24'h5, 8'h00, 24'h5);
        // macro choice bits set
        emit(8'h00, 1'b1);
        push_cell(TAG_CELL, 8'h00, 24'h6, 32'h6, 16'h6);
        emit(8'h00, 1'b0);
        push_enb(TAG_ENB, 8'h00, 8'h00, 24'h7, 8'h40, 24'h7);
        // restart inside a cell, then on the eNB header byte
        emit(8'h00, 1'b1);
        emit(8'h00, 1'b0);
        emit(8'hd6, 1'b0);
        emit(8'h40, 1'b0);
        emit(8'h00, 1'b1);
        push_cell(TAG_CELL, 8'($urandom), 24'($urandom), $urandom, 16'($urandom));
        emit(8'h00, 1'b1);
        push_cell(TAG_CELL, 8'($urandom), 24'($urandom), $urandom, 16'($urandom));
        emit(8'h00, 1'b0);
        push_enb(TAG_ENB, 8'($urandom), 8'h00, 24'($urandom), 8'h00, 24'($urandom));
        // longest lists
        queue_element(16, 16, FAULT_NONE, 0);
        directed_len = pending_bytes.size();

        while (pending_bytes.size() < directed_len + RANDOM_BYTES)
        begin
            sel     = $urandom_range(0, 99);
            n_cells = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 3);
            n_enbs  = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 3);
            if (sel < 70)
                queue_element(n_cells, n_enbs, FAULT_NONE, 0);
            else if (sel < 85)
            begin
                fault = fault_t'($urandom_range(1, 4));
                queue_element(n_cells, n_enbs, fault,
                              (fault == FAULT_CELL_TAG) ? $urandom_range(0, n_cells - 1)
                                                        : $urandom_range(0, n_enbs - 1));
            end
            else if (sel < 95)
            begin
                cut_left = $urandom_range(1, 1 + 14 * n_cells + 12 * n_enbs);
                queue_element(n_cells, n_enbs, FAULT_NONE, 0);
                cut_left = NO_CUT;
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    emit(8'($urandom), 1'b0);
            end
        end

        @(posedge rst_n);
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || s_axis_tvalid);
        while (expected_items.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("sent %0d bytes in %0d elements, checked %0d results (%0d errors)",
                 bytes_accepted, elements_sent, results_seen, error_results);
        $display("receiver hold-off of %0d cycles exercised, %0d mismatches",
                 HOLDOFF_LEN, mismatch_count);
        if (mismatch_count == 0 && expected_items.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/prie_pkg.sv
rtl/core/prie_parse.sv
rtl/core/paging_recommendation_ie_parser.sv
sim/tb_paging_recommendation_ie_parser.sv
